// ----- design/sjs_pkg.sv -----
// Shared command codes, status codes and cell control type for the SRPT job scheduler.
package sjs_pkg;

  localparam logic [1:0] CMD_ARRIVE = 2'd0;
  localparam logic [1:0] CMD_DEPART = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_EMPTY   = 3'd1;
  localparam logic [2:0] STAT_NOT_TOP = 3'd2;
  localparam logic [2:0] STAT_FULL    = 3'd3;
  localparam logic [2:0] STAT_OVERRUN = 3'd4;
  localparam logic [2:0] STAT_LEFT    = 3'd5;

  localparam int unsigned TAKE_BITS = 32;

  typedef struct packed {
    logic ins;
    logic pop;
    logic run;
  } cell_ctrl_t;

endpackage

// ----- design/sjs_cell.sv -----
// One slot of the sorted job queue: holds an id and remaining work, shifts with its neighbors.
module sjs_cell
  import sjs_pkg::*;
#(
  parameter int unsigned IDX       = 0,
  parameter int unsigned WORK_BITS = 32,
  parameter int unsigned CNT_W     = 6
) (
  input  logic                 clk_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic [15:0]          new_id_i,
  input  logic [WORK_BITS-1:0] new_rem_i,
  input  logic [TAKE_BITS-1:0] takeout_i,
  input  logic                 left_gt_i,
  input  logic [15:0]          left_id_i,
  input  logic [WORK_BITS-1:0] left_rem_i,
  input  logic [15:0]          right_id_i,
  input  logic [WORK_BITS-1:0] right_rem_i,
  output logic                 gt_o,
  output logic                 over_o,
  output logic [15:0]          id_o,
  output logic [WORK_BITS-1:0] rem_o,
  output logic [15:0]          id_d_o,
  output logic [WORK_BITS-1:0] rem_d_o
);

  localparam int unsigned CW = (WORK_BITS > TAKE_BITS) ? WORK_BITS : TAKE_BITS;

  logic [15:0]          id_q, id_d;
  logic [WORK_BITS-1:0] rem_q, rem_d;
  logic                 occ;
  logic [CW-1:0]        rem_ext, take_ext;
  logic                 over;

  assign occ      = CNT_W'(IDX) < count_i;
  assign gt_o     = !occ || (rem_q > new_rem_i);
  assign rem_ext  = CW'(rem_q);
  assign take_ext = CW'(takeout_i);

  generate
    if (IDX == 0) begin : g_head
      assign over = take_ext > rem_ext;
    end else begin : g_body
      assign over = 1'b0;
    end
  endgenerate

  assign over_o = over;

  always_comb begin
    id_d  = id_q;
    rem_d = rem_q;
    if (ctrl_i.ins && gt_o) begin
      if (left_gt_i) begin
        id_d  = left_id_i;
        rem_d = left_rem_i;
      end else begin
        id_d  = new_id_i;
        rem_d = new_rem_i;
      end
    end else if (ctrl_i.pop) begin
      id_d  = right_id_i;
      rem_d = right_rem_i;
    end else if (ctrl_i.run && (IDX == 0)) begin
      rem_d = over ? '0 : WORK_BITS'(rem_ext - take_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    rem_q <= rem_d;
  end

  assign id_o    = id_q;
  assign rem_o   = rem_q;
  assign id_d_o  = id_d;
  assign rem_d_o = rem_d;

endmodule

// ----- design/srpt_job_scheduler_core.sv -----
// Top level of the shortest-remaining-processing-time job scheduler.
// For each command the input transaction is registered and the
// 16x16 run product is formed, then the row of queue cells shifts, inserts or
// debits the head in one step and the result lands in the output register. A
// new command is accepted while the previous result waits; a stalled output
// holds the execute step, and no new command is accepted until it completes.
module srpt_job_scheduler_core
  import sjs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned WORK_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // command[1:0], job_id[17:2], job_size[49:18], duration[65:50], speed[81:66], zero pad
  input  logic [87:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[2:0], preempted[3], completed_id[19:4], running_id[35:20],
  // running_remaining[67:36], queue_count[73:68], zero pad
  output logic [79:0] m_axis_tdata_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW    = (WORK_BITS > 32) ? WORK_BITS : 32;
  localparam logic        S_IDLE = 1'b0;
  localparam logic        S_EXEC = 1'b1;

  logic                 state_q, state_d;
  logic [1:0]           cmd_q;
  logic [15:0]          id_q;
  logic [WORK_BITS-1:0] size_q;
  logic [TAKE_BITS-1:0] take_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 out_valid_q;
  logic [79:0]          out_data_q;

  logic                 accept, go;
  logic [SW-1:0]        size_ext, wmax, size_sat;
  cell_ctrl_t           ctrl;
  logic [2:0]           status;
  logic                 preempted;
  logic [15:0]          completed;
  logic [15:0]          run_id;
  logic [31:0]          run_rem;

  logic [15:0]          c_id    [QUEUE_DEPTH];
  logic [WORK_BITS-1:0] c_rem   [QUEUE_DEPTH];
  logic [15:0]          c_id_d  [QUEUE_DEPTH];
  logic [WORK_BITS-1:0] c_rem_d [QUEUE_DEPTH];
  logic                 c_gt    [QUEUE_DEPTH];
  logic                 c_over  [QUEUE_DEPTH];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign go              = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready_i);

  assign size_ext = SW'(s_axis_tdata_i[49:18]);
  assign wmax     = SW'({WORK_BITS{1'b1}});
  assign size_sat = (size_ext > wmax) ? wmax : size_ext;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tdata_i[1:0];
      id_q   <= s_axis_tdata_i[17:2];
      size_q <= WORK_BITS'(size_sat);
      take_q <= TAKE_BITS'(s_axis_tdata_i[65:50]) * TAKE_BITS'(s_axis_tdata_i[81:66]);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic                 l_gt;
      logic [15:0]          l_id, r_id;
      logic [WORK_BITS-1:0] l_rem, r_rem;
      if (gi == 0) begin : g_first
        assign l_gt  = 1'b0;
        assign l_id  = '0;
        assign l_rem = '0;
      end else begin : g_mid
        assign l_gt  = c_gt[gi-1];
        assign l_id  = c_id[gi-1];
        assign l_rem = c_rem[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign r_id  = '0;
        assign r_rem = '0;
      end else begin : g_inner
        assign r_id  = c_id[gi+1];
        assign r_rem = c_rem[gi+1];
      end
      sjs_cell #(
        .IDX       (gi),
        .WORK_BITS (WORK_BITS),
        .CNT_W     (CNT_W)
      ) u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .count_i     (count_q),
        .new_id_i    (id_q),
        .new_rem_i   (size_q),
        .takeout_i   (take_q),
        .left_gt_i   (l_gt),
        .left_id_i   (l_id),
        .left_rem_i  (l_rem),
        .right_id_i  (r_id),
        .right_rem_i (r_rem),
        .gt_o        (c_gt[gi]),
        .over_o      (c_over[gi]),
        .id_o        (c_id[gi]),
        .rem_o       (c_rem[gi]),
        .id_d_o      (c_id_d[gi]),
        .rem_d_o     (c_rem_d[gi])
      );
    end
  endgenerate

  always_comb begin
    ctrl      = '0;
    status    = STAT_OK;
    preempted = 1'b0;
    completed = '0;
    count_d   = count_q;
    case (cmd_q)
      CMD_ARRIVE: begin
        if (count_q == CNT_W'(QUEUE_DEPTH)) begin
          status = STAT_FULL;
        end else begin
          ctrl.ins  = go;
          preempted = c_gt[0];
          count_d   = count_q + CNT_W'(1);
        end
      end
      CMD_DEPART: begin
        if (count_q == '0) begin
          status = STAT_EMPTY;
        end else if (c_id[0] != id_q) begin
          status = STAT_NOT_TOP;
        end else begin
          ctrl.pop  = go;
          status    = (c_rem[0] != '0) ? STAT_LEFT : STAT_OK;
          completed = id_q;
          count_d   = count_q - CNT_W'(1);
        end
      end
      CMD_RUN: begin
        if (count_q == '0) begin
          status = STAT_EMPTY;
        end else begin
          ctrl.run = go;
          status   = c_over[0] ? STAT_OVERRUN : STAT_OK;
        end
      end
      default: begin
        status = STAT_OK;
      end
    endcase
  end

  assign run_id  = (count_d != '0) ? c_id_d[0] : '0;
  assign run_rem = (count_d != '0) ? 32'(c_rem_d[0]) : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (go) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_data_q <= {6'd0, 6'(count_d), run_rem, run_id, completed, preempted, status};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
